>>> rtl/core/khf_pkg.sv
`default_nettype none

package khf_pkg;

    localparam int NUM_HOTKEYS = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    // register indexes, in priority order
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_LAST      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_SELECTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_AUTO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDO           = 3'd3;

    // key event values
    localparam logic [1:0] KV_RELEASE = 2'd0;
    localparam logic [1:0] KV_PRESS   = 2'd1;
    localparam logic [1:0] KV_REPEAT  = 2'd2;

    // key codes of interest
    localparam logic [7:0] K_BACKSPACE  = 8'd14;
    localparam logic [7:0] K_LEFTCTRL   = 8'd29;
    localparam logic [7:0] K_LEFTSHIFT  = 8'd42;
    localparam logic [7:0] K_RIGHTSHIFT = 8'd54;
    localparam logic [7:0] K_LEFTALT    = 8'd56;
    localparam logic [7:0] K_CAPSLOCK   = 8'd58;
    localparam logic [7:0] K_RIGHTCTRL  = 8'd97;
    localparam logic [7:0] K_RIGHTALT   = 8'd100;
    localparam logic [7:0] K_DELETE     = 8'd111;
    localparam logic [7:0] K_LEFTMETA   = 8'd125;
    localparam logic [7:0] K_RIGHTMETA  = 8'd126;

    typedef enum logic [1:0] {
        ACT_FORWARD = 2'd0,
        ACT_DROP    = 2'd1,
        ACT_HOTKEY  = 2'd2
    } t_action;

    // modifier mask bits: 0 alt, 1 shift, 2 ctrl, 3 super
    typedef struct packed {
        logic [7:0] alt_key;
        logic [7:0] main_key;
        logic [3:0] mask;
    } t_hotkey;

    typedef struct packed {
        logic       hit;
        logic [1:0] index;
    } t_match;

endpackage

`default_nettype wire

>>> rtl/core/khf_hotkey_match.sv
`default_nettype none

module khf_hotkey_match (
    input  khf_pkg::t_hotkey [khf_pkg::NUM_HOTKEYS-1:0] i_hotkey,
    input  logic [7:0]                                  i_code,
    input  logic [3:0]                                  i_mods,
    output khf_pkg::t_match                             o_match
);
    import khf_pkg::*;

    logic [NUM_HOTKEYS-1:0] hit;

    always_comb begin
        for (int i = 0; i < NUM_HOTKEYS; i++) begin
            hit[i] = (i_hotkey[i].main_key != 8'd0) &&
                     ((i_code == i_hotkey[i].main_key) ||
                      ((i_hotkey[i].alt_key != 8'd0) && (i_code == i_hotkey[i].alt_key))) &&
                     (i_mods == i_hotkey[i].mask);
        end
    end

    // lowest index wins
    always_comb begin
        o_match.hit   = |hit;
        o_match.index = 2'd0;
        for (int i = NUM_HOTKEYS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                o_match.index = 2'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/key_event_hotkey_filter.sv
`default_nettype none

// Keyboard event hotkey filter.
// Input channel: i_valid / o_stall with i_is_key_event, i_key_code, i_key_value.
// A request is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with the decision for that event:
// forward, drop a swallowed release, or hotkey consumed (o_hotkey_index),
// plus caps-lock state and the refresh / text / word-reset flags.
// Path: a request lands in the input register at its accept edge and its
// result moves to the output register when that register is empty or
// drains. Throughput: one event per cycle while i_stall is low; the held/swallowed
// bitmaps are read and written in the same cycle, so there is no hazard.
// Config: i_cfg_we writes hotkey register i_cfg_index; index four and up is
// ignored. Write only while the block is idle.
// Reset (i_rst_n low, synchronous): bitmaps, flags, hotkeys and valids clear.
// When the receiver stalls, the result holds and the input register holds;
// o_stall then rises once the input register is full, so nothing is lost.
module key_event_hotkey_filter #(
    parameter int KEY_COUNT = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [khf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [khf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // event input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_is_key_event,
    input  logic [9:0]                          i_key_code,
    input  logic [1:0]                          i_key_value,
    // result output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_action,
    output logic [1:0]                          o_hotkey_index,
    output logic                                o_caps_lock_on,
    output logic                                o_refresh_wait,
    output logic                                o_text_candidate,
    output logic                                o_word_reset
);
    import khf_pkg::*;

    localparam int IDX_W = $clog2(KEY_COUNT);

    // hotkey registers
    t_hotkey [NUM_HOTKEYS-1:0] r_hotkey;

    // input register
    logic        r_s1_valid;
    logic        r_s1_key;
    logic [9:0]  r_s1_code;
    logic [1:0]  r_s1_val;

    // tracking state
    logic [KEY_COUNT-1:0] r_held, n_held;
    logic [KEY_COUNT-1:0] r_swal, n_swal;
    logic                 r_caps, n_caps;
    logic                 r_oms, n_oms;
    logic                 r_rp, n_rp;

    // output register
    logic       r_out_valid;
    t_action    r_out_action, n_out_action;
    logic [1:0] r_out_index, n_out_index;
    logic       r_out_caps;
    logic       r_out_refresh, n_out_refresh;
    logic       r_out_text, n_out_text;
    logic       r_out_wreset, n_out_wreset;

    logic                 out_ready;
    logic                 s1_advance;
    logic                 in_range;
    logic [IDX_W-1:0]     idx;
    logic [KEY_COUNT-1:0] held_upd;
    logic [3:0]           mods;
    logic                 is_mod;
    t_match               match;

    // handshake: output register drains or is empty -> input register may advance
    assign out_ready  = !r_out_valid || !i_stall;
    assign s1_advance = r_s1_valid && out_ready;
    assign o_stall    = r_s1_valid && !out_ready;

    assign in_range = ({1'b0, r_s1_code} < 11'(KEY_COUNT));
    assign idx      = r_s1_code[IDX_W-1:0];

    // held bitmap with this event applied; modifiers are sampled after the update
    always_comb begin
        held_upd = r_held;
        case (r_s1_val)
            KV_PRESS, KV_REPEAT: held_upd[idx] = 1'b1;
            KV_RELEASE:          held_upd[idx] = 1'b0;
            default:             held_upd[idx] = r_held[idx];
        endcase
    end

    assign mods[0] = held_upd[K_LEFTALT]   || held_upd[K_RIGHTALT];
    assign mods[1] = held_upd[K_LEFTSHIFT] || held_upd[K_RIGHTSHIFT];
    assign mods[2] = held_upd[K_LEFTCTRL]  || held_upd[K_RIGHTCTRL];
    assign mods[3] = held_upd[K_LEFTMETA]  || held_upd[K_RIGHTMETA];

    assign is_mod = (r_s1_code == {2'b00, K_LEFTCTRL})  || (r_s1_code == {2'b00, K_RIGHTCTRL})  ||
                    (r_s1_code == {2'b00, K_LEFTSHIFT}) || (r_s1_code == {2'b00, K_RIGHTSHIFT}) ||
                    (r_s1_code == {2'b00, K_LEFTALT})   || (r_s1_code == {2'b00, K_RIGHTALT})   ||
                    (r_s1_code == {2'b00, K_LEFTMETA})  || (r_s1_code == {2'b00, K_RIGHTMETA});

    khf_hotkey_match u_match (
        .i_hotkey (r_hotkey),
        .i_code   (r_s1_code[7:0]),
        .i_mods   (mods),
        .o_match  (match)
    );

    // event decision and state update
    always_comb begin
        n_held        = r_held;
        n_swal        = r_swal;
        n_caps        = r_caps;
        n_oms         = r_oms;
        n_rp          = r_rp;
        n_out_action  = ACT_FORWARD;
        n_out_index   = 2'd0;
        n_out_refresh = 1'b0;
        n_out_text    = 1'b0;
        n_out_wreset  = 1'b0;

        if (s1_advance && r_s1_key && in_range) begin
            if (r_s1_val == KV_RELEASE && r_swal[idx]) begin
                // paired release of a consumed hotkey: drop it
                n_swal[idx]  = 1'b0;
                n_held[idx]  = 1'b0;
                n_out_action = ACT_DROP;
            end else begin
                n_held = held_upd;
                if (r_s1_code == {2'b00, K_CAPSLOCK} && r_s1_val == KV_PRESS) begin
                    n_caps = !r_caps;
                end
                if (r_s1_val == KV_PRESS && match.hit) begin
                    n_swal[idx]  = 1'b1;
                    n_out_action = ACT_HOTKEY;
                    n_out_index  = match.index;
                end else begin
                    // modifier-only sequence tracking
                    if (r_s1_val == KV_PRESS && is_mod) begin
                        n_oms = 1'b1;
                    end else if (r_s1_val == KV_RELEASE && is_mod) begin
                        if (!(|mods) && r_oms) begin
                            n_rp = 1'b1;
                        end
                    end else if (r_s1_val == KV_PRESS && !is_mod) begin
                        n_out_refresh = r_rp;
                        n_rp          = 1'b0;
                        n_oms         = 1'b0;
                    end

                    if (r_s1_val == KV_PRESS || r_s1_val == KV_REPEAT) begin
                        if (r_s1_code == {2'b00, K_BACKSPACE} ||
                            r_s1_code == {2'b00, K_DELETE}) begin
                            n_out_wreset = 1'b1;
                        end else if (!(mods[2] || mods[0] || mods[3])) begin
                            n_out_text = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hotkey    <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_swal      <= '0;
            r_caps      <= 1'b0;
            r_oms       <= 1'b0;
            r_rp        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SWAP_LAST:      r_hotkey[0] <= i_cfg_data;
                    CFG_SWAP_SELECTION: r_hotkey[1] <= i_cfg_data;
                    CFG_TOGGLE_AUTO:    r_hotkey[2] <= i_cfg_data;
                    CFG_UNDO:           r_hotkey[3] <= i_cfg_data;
                    default:            ; // no register there: ignore
                endcase
            end
            // input register: refill when empty or moving on
            if (!r_s1_valid || s1_advance) begin
                r_s1_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
            r_held <= n_held;
            r_swal <= n_swal;
            r_caps <= n_caps;
            r_oms  <= n_oms;
            r_rp   <= n_rp;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_s1_key  <= i_is_key_event;
            r_s1_code <= i_key_code;
            r_s1_val  <= i_key_value;
        end
        if (s1_advance) begin
            r_out_action  <= n_out_action;
            r_out_index   <= n_out_index;
            r_out_caps    <= n_caps;
            r_out_refresh <= n_out_refresh;
            r_out_text    <= n_out_text;
            r_out_wreset  <= n_out_wreset;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_action         = r_out_action;
    assign o_hotkey_index   = r_out_index;
    assign o_caps_lock_on   = r_out_caps;
    assign o_refresh_wait   = r_out_refresh;
    assign o_text_candidate = r_out_text;
    assign o_word_reset     = r_out_wreset;

`ifndef SYNTH
    // a consumed hotkey never reports the event flags
    a_hotkey_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action == ACT_HOTKEY) |->
        (!o_refresh_wait && !o_text_candidate && !o_word_reset))
        else $error("hotkey result carries event flags");

    // text and word reset are exclusive
    a_text_wreset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_text_candidate && o_word_reset))
        else $error("text candidate and word reset both set");

    // a consumed hotkey press marks its key so the release is dropped
    a_swallow_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && r_s1_key && in_range && n_out_action == ACT_HOTKEY) |=>
        r_swal[$past(idx)])
        else $error("hotkey key not marked swallowed");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import khf_pkg::*;

    localparam int KEY_COUNT = 256;
    // watchdog: cycles in a row with no request and no result moving
    localparam int QUIET_LIMIT = 4000;
    // register index past the hotkey set; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
    // key value that is neither release, press nor repeat
    localparam logic [1:0] KV_UNUSED = 2'd3;
    localparam int ROUNDS = 12;
    localparam int ROUND_EVENTS = 145;

    // what the block must report for one request
    typedef struct packed {
        t_action    action;
        logic [1:0] hk_index;
        logic       caps;
        logic       refresh;
        logic       text;
        logic       wreset;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_is_key_event;
    logic [9:0]            i_key_code;
    logic [1:0]            i_key_value;
    logic                  o_valid;
    logic                  i_stall;
    logic [1:0]            o_action;
    logic [1:0]            o_hotkey_index;
    logic                  o_caps_lock_on;
    logic                  o_refresh_wait;
    logic                  o_text_candidate;
    logic                  o_word_reset;

    // shadow of the filter state
    t_hotkey      hotkeys [NUM_HOTKEYS];
    logic [255:0] held_map;
    logic [255:0] swallow_map;
    logic         caps_state;
    logic         mods_only;
    logic         refresh_due;

    t_verdict verdicts_due[$];
    int       events_sent = 0;
    int       err_cnt = 0;
    int       quiet_cycles = 0;
    int       src_idle_pct = 0;
    int       sink_stall_pct = 0;
    int       config_round = 0;

    key_event_hotkey_filter #(.KEY_COUNT(KEY_COUNT)) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_is_key_event   (i_is_key_event),
        .i_key_code       (i_key_code),
        .i_key_value      (i_key_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_action         (o_action),
        .o_hotkey_index   (o_hotkey_index),
        .o_caps_lock_on   (o_caps_lock_on),
        .o_refresh_wait   (o_refresh_wait),
        .o_text_candidate (o_text_candidate),
        .o_word_reset     (o_word_reset)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Filter prediction
    // ------------------------------------------------------------------

    // held modifier groups as {super, ctrl, shift, alt}
    function automatic logic [3:0] mods_now();
        return {held_map[K_LEFTMETA] | held_map[K_RIGHTMETA],
                held_map[K_LEFTCTRL] | held_map[K_RIGHTCTRL],
                held_map[K_LEFTSHIFT] | held_map[K_RIGHTSHIFT],
                held_map[K_LEFTALT] | held_map[K_RIGHTALT]};
    endfunction

    function automatic logic is_mod_key(logic [7:0] k);
        return k == K_LEFTCTRL || k == K_RIGHTCTRL || k == K_LEFTSHIFT ||
               k == K_RIGHTSHIFT || k == K_LEFTALT || k == K_RIGHTALT ||
               k == K_LEFTMETA || k == K_RIGHTMETA;
    endfunction

    // a zero main key disables the hotkey; a zero alternate key means none
    function automatic logic hotkey_fires(t_hotkey h, logic [7:0] k);
        if (h.main_key == '0)
            return 1'b0;
        if (k != h.main_key && (h.alt_key == '0 || k != h.alt_key))
            return 1'b0;
        return mods_now() == h.mask;
    endfunction

    // Advance the shadow state by one event and return the expected verdict.
    function automatic t_verdict filter_event(logic is_key, logic [9:0] code,
                                              logic [1:0] val);
        t_verdict   v;
        logic [7:0] k;
        logic       hit;
        logic       mod;
        v   = '0;
        hit = 1'b0;
        k   = code[7:0];
        if (is_key && code < KEY_COUNT) begin
            if (val == KV_RELEASE && swallow_map[k]) begin
                // paired release of a consumed hotkey: drop it
                swallow_map[k] = 1'b0;
                held_map[k]    = 1'b0;
                v.action       = ACT_DROP;
            end else begin
                if (val == KV_PRESS || val == KV_REPEAT)
                    held_map[k] = 1'b1;
                else if (val == KV_RELEASE)
                    held_map[k] = 1'b0;
                if (k == K_CAPSLOCK && val == KV_PRESS)
                    caps_state = ~caps_state;
                if (val == KV_PRESS) begin
                    for (int i = 0; i < NUM_HOTKEYS; i++) begin
                        if (!hit && hotkey_fires(hotkeys[i], k)) begin
                            hit            = 1'b1;
                            swallow_map[k] = 1'b1;
                            v.action       = ACT_HOTKEY;
                            v.hk_index     = 2'(i);
                        end
                    end
                end
                if (!hit) begin
                    mod = is_mod_key(k);
                    if (val == KV_PRESS && mod) begin
                        mods_only = 1'b1;
                    end else if (val == KV_RELEASE && mod) begin
                        if (mods_now() == '0 && mods_only)
                            refresh_due = 1'b1;
                    end else if (val == KV_PRESS && !mod) begin
                        v.refresh   = refresh_due;
                        refresh_due = 1'b0;
                        mods_only   = 1'b0;
                    end
                    if (val == KV_PRESS || val == KV_REPEAT) begin
                        if (k == K_BACKSPACE || k == K_DELETE)
                            v.wreset = 1'b1;
                        else
                            v.text = (mods_now() & 4'b1101) == '0;
                    end
                end
            end
        end
        v.caps = caps_state;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // compare each accepted result with the oldest outstanding request
    always @(posedge i_clk) begin : check_result
        t_verdict want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none, actual %0d",
                         $time, o_action);
                err_cnt++;
            end else begin
                want = verdicts_due.pop_front();
                check_field("action", want.action, o_action);
                check_field("hotkey_index", want.hk_index, o_hotkey_index);
                check_field("caps_lock_on", want.caps, o_caps_lock_on);
                check_field("refresh_wait", want.refresh, o_refresh_wait);
                check_field("text_candidate", want.text, o_text_candidate);
                check_field("word_reset", want.wreset, o_word_reset);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, verdicts_due.size());
                $display("tb: errors");
                $finish;
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < sink_stall_pct);

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one request; valid stays high if the next request follows at once.
    task automatic send_event(logic is_key, logic [9:0] code, logic [1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_is_key_event <= is_key;
        i_key_code     <= code;
        i_key_value    <= val;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        verdicts_due.insert(verdicts_due.size(), filter_event(is_key, code, val));
        events_sent++;
    endtask

    task automatic press_key(logic [7:0] k, logic [1:0] val);
        send_event(1'b1, {2'b00, k}, val);
    endtask

    // Hold off the sender until every result is back, then let the pipe settle.
    task automatic wait_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write one hotkey register; call only with the block drained.
    task automatic write_hotkey(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < NUM_HOTKEYS)
            hotkeys[idx] = val;
    endtask

    // ------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------

    // group: 0 alt, 1 shift, 2 ctrl, 3 super (mask bit order)
    function automatic logic [7:0] modifier_code(int group, logic right);
        case (group)
            0:       return right ? K_RIGHTALT : K_LEFTALT;
            1:       return right ? K_RIGHTSHIFT : K_LEFTSHIFT;
            2:       return right ? K_RIGHTCTRL : K_LEFTCTRL;
            default: return right ? K_RIGHTMETA : K_LEFTMETA;
        endcase
    endfunction

    // keep hotkey codes in a narrow band so hotkeys collide and priority shows
    function automatic logic [7:0] hotkey_code();
        case ($urandom_range(5))
            0:       return K_CAPSLOCK;
            1:       return K_BACKSPACE;
            2:       return 8'd255;
            3:       return modifier_code($urandom_range(3), 1'($urandom_range(1)));
            default: return 8'($urandom_range(24, 32));
        endcase
    endfunction

    function automatic t_hotkey random_hotkey();
        t_hotkey h;
        h.mask     = 4'($urandom_range(15));
        h.main_key = ($urandom_range(9) == 0) ? 8'd0 : hotkey_code();
        h.alt_key  = ($urandom_range(1) == 0) ? 8'd0 : hotkey_code();
        return h;
    endfunction

    function automatic logic [7:0] chord_target(t_hotkey h);
        case ($urandom_range(5))
            0, 1:    return (h.main_key != '0) ? h.main_key : 8'($urandom_range(24, 32));
            2:       return (h.alt_key != '0) ? h.alt_key : K_DELETE;
            3:       return $urandom_range(1) ? K_CAPSLOCK : K_BACKSPACE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Modifiers down, one key pressed, maybe repeated, released, modifiers up.
    // Now and then leave the key down to break the sequence.
    task automatic play_chord();
        t_hotkey    h;
        logic [3:0] mods;
        logic [7:0] k;
        logic [7:0] mod_down [4];
        h    = hotkeys[$urandom_range(NUM_HOTKEYS - 1)];
        mods = $urandom_range(1) ? h.mask : 4'($urandom_range(15));
        k    = chord_target(h);
        for (int g = 0; g < 4; g++) begin
            mod_down[g] = modifier_code(g, 1'($urandom_range(1)));
            if (mods[g])
                press_key(mod_down[g], KV_PRESS);
        end
        press_key(k, KV_PRESS);
        repeat ($urandom_range(2))
            press_key(k, KV_REPEAT);
        if ($urandom_range(9) != 0)
            press_key(k, KV_RELEASE);
        for (int g = 3; g >= 0; g--)
            if (mods[g])
                press_key(mod_down[g], KV_RELEASE);
    endtask

    // one arbitrary event: any flag, any code up to ten bits, any value
    task automatic send_noise();
        logic [9:0] code;
        code = $urandom_range(1) ? 10'($urandom_range(255)) : 10'($urandom_range(1023));
        send_event(1'($urandom_range(1)), code, 2'($urandom_range(3)));
    endtask

    // New hotkey setting, clear stuck modifiers, then chords mixed with noise.
    // Round zero sets every bit, the last round clears them all.
    task automatic run_round(int n_events);
        int       stop_at;
        int       paused;
        t_hotkey  setting;
        wait_until_drained();
        for (int j = 0; j < NUM_HOTKEYS; j++) begin
            if (config_round == 0)
                setting = '1;
            else if (config_round == ROUNDS - 1)
                setting = '0;
            else
                setting = random_hotkey();
            write_hotkey(CFG_IDX_W'(j), setting);
        end
        config_round++;
        stop_at = events_sent + n_events;
        paused  = 0;
        for (int j = 0; j < 8; j++)
            press_key(modifier_code(j / 2, 1'(j % 2)), KV_RELEASE);
        while (events_sent < stop_at) begin
            // hold the sender once per round until the block is empty
            if (!paused && events_sent >= stop_at - n_events / 2) begin
                wait_until_drained();
                paused = 1;
            end
            if ($urandom_range(99) < 20)
                send_noise();
            else
                play_chord();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No hotkeys set: out-of-range codes, non-key events, the unused key
    // value, word-reset keys and caps lock all pass through.
    task automatic test_passthrough();
        send_event(1'b0, 10'd30, KV_PRESS);
        send_event(1'b1, 10'd1023, KV_PRESS);
        send_event(1'b1, 10'd256, KV_RELEASE);
        press_key(8'd0, KV_PRESS);
        press_key(8'd255, KV_UNUSED);
        press_key(K_BACKSPACE, KV_PRESS);
        press_key(K_BACKSPACE, KV_REPEAT);
        press_key(K_DELETE, KV_PRESS);
        press_key(K_CAPSLOCK, KV_PRESS);
    endtask

    // Shift alone arms the refresh; the next plain press consumes it.
    // With ctrl down a press is not a text candidate.
    task automatic test_modifier_sequence();
        press_key(K_LEFTSHIFT, KV_PRESS);
        press_key(K_LEFTSHIFT, KV_RELEASE);
        press_key(8'd30, KV_PRESS);
        press_key(K_RIGHTCTRL, KV_PRESS);
        press_key(8'd30, KV_PRESS);
        press_key(K_RIGHTCTRL, KV_RELEASE);
    endtask

    // Two hotkeys on the same combo (first wins), an alternate key, caps lock
    // as a hotkey (still toggles), swallowed releases, and the all-ones
    // register needing every modifier group.
    task automatic test_hotkeys();
        t_hotkey h;
        wait_until_drained();
        h = '{alt_key: 8'd48, main_key: 8'd30, mask: 4'b0100};
        write_hotkey(CFG_SWAP_LAST, h);
        h = '{alt_key: 8'd0, main_key: 8'd30, mask: 4'b0100};
        write_hotkey(CFG_SWAP_SELECTION, h);
        h = '{alt_key: 8'd0, main_key: K_CAPSLOCK, mask: 4'b0000};
        write_hotkey(CFG_TOGGLE_AUTO, h);
        write_hotkey(CFG_UNDO, '1);
        write_hotkey(CFG_UNMAPPED, '1);
        press_key(K_LEFTCTRL, KV_PRESS);
        press_key(8'd30, KV_PRESS);
        press_key(8'd30, KV_RELEASE);
        press_key(8'd48, KV_PRESS);
        press_key(K_LEFTCTRL, KV_RELEASE);
        press_key(K_CAPSLOCK, KV_PRESS);
        press_key(K_CAPSLOCK, KV_RELEASE);
        press_key(K_LEFTALT, KV_PRESS);
        press_key(K_RIGHTSHIFT, KV_PRESS);
        press_key(K_LEFTCTRL, KV_PRESS);
        press_key(K_RIGHTMETA, KV_PRESS);
        press_key(8'd255, KV_PRESS);
    endtask

    task automatic test_random_traffic(int src_pct, int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (ROUNDS / 3)
            run_round(ROUND_EVENTS);
    endtask

    initial begin
        // drive every input before the first edge and hold reset
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_is_key_event = 1'b0;
        i_key_code     = '0;
        i_key_value    = KV_RELEASE;
        i_stall        = 1'b0;
        for (int j = 0; j < NUM_HOTKEYS; j++)
            hotkeys[j] = '0;
        held_map    = '0;
        swallow_map = '0;
        caps_state  = 1'b0;
        mods_only   = 1'b0;
        refresh_due = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct   = 33;
        sink_stall_pct = 68;
        test_passthrough();
        test_modifier_sequence();
        test_hotkeys();
        test_random_traffic(33, 68);
        test_random_traffic(68, 33);
        test_random_traffic(0, 0);

        wait_until_drained();
        repeat (5) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/core/khf_pkg.sv
rtl/core/khf_hotkey_match.sv
rtl/core/key_event_hotkey_filter.sv
tb/sv/tb.sv
